// ----- hdl/stepper_ramp_period_generator_core_macros.svh -----
// Assertion macros for the stepper ramp period generator checker.
// No dependencies; included by the checker file.
`ifndef STEPPER_RAMP_PERIOD_GENERATOR_CORE_MACROS_SVH
`define STEPPER_RAMP_PERIOD_GENERATOR_CORE_MACROS_SVH

// same-cycle implication
`define SRPG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srpg check failed");

// next-cycle implication
`define SRPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srpg check failed");

`endif

// ----- hdl/srpg_pkg.sv -----
// Shared constants and types for the stepper ramp period generator.
// No dependencies.
`default_nettype none
package srpg_pkg;

   localparam int TICK_HZ_DEF = 62500000;
   localparam int SLOTS_DEF   = 32;

   localparam logic [15:0] OFF_WORD  = 16'd3199;
   localparam logic [15:0] LAST_RST  = 16'd65000;
   localparam logic [19:0] ACCEL_RST = 20'd1000;

   localparam logic [31:0] FULL_Q = 32'hFFFF_0000;
   localparam logic [31:0] SAT_Q  = 32'hFFFF_FFFF;
   localparam logic [31:0] ONE_Q  = 32'h0001_0000;
   localparam logic [31:0] FAST_Q = 32'd917504000;   // 14000.0
   localparam logic [31:0] STOP_Q = 32'hFFFE_0000;   // 65534.0

   localparam int OPND_W = 64;
   localparam int PROD_W = 128;
   localparam int QUO_W  = 42;
   localparam int REM_W  = 136;

   localparam logic [1:0] CSR_SPEED_LIMIT = 2'd0;
   localparam logic [1:0] CSR_ACCEL       = 2'd1;
   localparam logic [1:0] CSR_INVERT      = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage
`default_nettype wire

// ----- hdl/srpg_mul.sv -----
// Shared 64x64 multiplier, one 32x32 partial product per cycle.
// Depends on srpg_pkg.
`default_nettype none
module srpg_mul (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [srpg_pkg::OPND_W-1:0] op_a,
   input  wire logic [srpg_pkg::OPND_W-1:0] op_b,
   output srpg_pkg::unit_stat_type          stat,
   output logic      [srpg_pkg::PROD_W-1:0] prod
);
   logic [srpg_pkg::OPND_W-1:0] a_ff, b_ff;
   logic [srpg_pkg::PROD_W-1:0] acc_ff;
   logic [1:0]                  k_ff;
   logic                        busy_ff, done_ff;
   logic [31:0]                 a_half, b_half;
   logic [63:0]                 pp;
   logic [1:0]                  lane;
   logic [srpg_pkg::PROD_W-1:0] pp_ext;

   always_comb begin
      a_half = k_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_half = k_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp     = {32'b0, a_half} * {32'b0, b_half};
      lane   = {k_ff[1] & k_ff[0], k_ff[1] ^ k_ff[0]};
      pp_ext = {64'b0, pp} << {lane, 5'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && k_ff == 2'd3) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= op_a;
         b_ff   <= op_b;
         acc_ff <= '0;
         k_ff   <= 2'd0;
      end else if (busy_ff) begin
         acc_ff <= acc_ff + pp_ext;
         k_ff   <= k_ff + 2'd1;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign prod      = acc_ff;
endmodule
`default_nettype wire

// ----- hdl/srpg_div.sv -----
// Restoring divider, one quotient bit per cycle, 42 quotient bits.
// A quotient of 2^41 or more shows with its top bit set. Depends on srpg_pkg.
`default_nettype none
module srpg_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [srpg_pkg::PROD_W-1:0] num,
   input  wire logic [srpg_pkg::PROD_W-1:0] den,
   output srpg_pkg::unit_stat_type          stat,
   output logic      [srpg_pkg::QUO_W-1:0]  quo
);
   localparam int REM_W = srpg_pkg::REM_W;
   localparam int QUO_W = srpg_pkg::QUO_W;
   localparam int PAD_W = REM_W - srpg_pkg::PROD_W;

   logic [REM_W-1:0] rem_ff, dsh_ff;
   logic [QUO_W-1:0] q_ff;
   logic [5:0]       cnt_ff;
   logic             busy_ff, done_ff;
   logic             ge;

   assign ge = rem_ff >= dsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 6'd0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {{PAD_W{1'b0}}, num};
         dsh_ff <= {{PAD_W{1'b0}}, den} << (QUO_W - 1);
         q_ff   <= '0;
         cnt_ff <= 6'(QUO_W - 1);
      end else if (busy_ff) begin
         if (ge) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         q_ff   <= {q_ff[QUO_W-2:0], ge};
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff - 6'd1;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = q_ff;
endmodule
`default_nettype wire

// ----- hdl/stepper_ramp_period_generator_core.sv -----
// Channel  Handshake              Payload
// req      req_valid/req_ready    target_is_position, target_position, target_speed
// rsp      rsp_valid/rsp_ready    period_word, dir_pin, position_now, is_running
// csr      csr_valid/csr_ready    csr_index, csr_wdata (always ready)
//
// One request at a time. An idle slot goes from HEAD straight to FIN, repeat
// and at-target slots pass through PLAN; a ramp slot also passes MUL, DIV, APPLY
// and WORD: seven products through the shared multiplier, 42 bits in the divider.
// Reset is synchronous; the result sits in an output register, so a new
// request is taken while the previous result waits for rsp_ready.
// Depends on srpg_pkg, srpg_mul, srpg_div.
`default_nettype none
module stepper_ramp_period_generator_core #(
   parameter int TICK_HZ          = srpg_pkg::TICK_HZ_DEF,
   parameter int SLOTS_PER_BUFFER = srpg_pkg::SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_target_is_position,
   input  wire logic [31:0] req_target_position,
   input  wire logic [15:0] req_target_speed,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_period_word,
   output logic             rsp_dir_pin,
   output logic [31:0]      rsp_position_now,
   output logic             rsp_is_running,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [19:0] csr_wdata
);
   localparam int SLOT_W = $clog2(SLOTS_PER_BUFFER);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS_PER_BUFFER - 1);
   localparam logic [63:0]  FQ     = 64'(TICK_HZ) << 16;
   localparam logic [127:0] FQ_W   = {64'b0, FQ};
   localparam logic [127:0] BRAKE  = 128'(3) * FQ_W * FQ_W;
   localparam int SPEED_CAP = TICK_HZ / 3200 - 80;
   localparam logic [16:0] SPEED_CAP_W = 17'(SPEED_CAP);
   localparam logic [14:0] SPEED_LIMIT_RST =
      (SPEED_CAP > 32767) ? 15'd32767 : 15'(SPEED_CAP);
   localparam logic [41:0] STEP_CLAMP = 42'd1 << 40;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_HEAD  = 8'b0000_0010,
      ST_PLAN  = 8'b0000_0100,
      ST_MUL   = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_APPLY = 8'b0010_0000,
      ST_WORD  = 8'b0100_0000,
      ST_FIN   = 8'b1000_0000
   } state_type;

   typedef enum logic [2:0] {
      OP_DD   = 3'd0,
      OP_TOGO = 3'd1,
      OP_ROOM = 3'd2,
      OP_CMP  = 3'd3,
      OP_AD   = 3'd4,
      OP_N    = 3'd5,
      OP_P    = 3'd6
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic        mode_ff;
   logic [31:0] tp_ff;
   logic [15:0] raw_ff;

   logic [14:0] speed_limit_ff;
   logic [19:0] accel_ff;
   logic        invert_ff;

   logic [31:0]       d_ff, d_in;
   logic [31:0]       pos_ff, pos_in;
   logic              rev_ff, rev_in;
   logic              run_ff, run_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [15:0]       last_ff, last_in;
   logic [15:0]       word_ff, word_in;

   logic          mul_issue_ff, mul_issue_in;
   logic          div_issue_ff, div_issue_in;
   logic [63:0]   dd_ff, dd_in, t_ff, t_in, ad_ff, ad_in;
   logic [127:0]  n_ff, n_in, p_ff, p_in;
   logic          room_big_ff, room_big_in, up_ff, up_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_word_ff;
   logic        rsp_dir_ff, rsp_run_ff;
   logic [31:0] rsp_pos_ff;
   logic        rsp_load;

   srpg_pkg::unit_stat_type mul_stat, div_stat;
   logic [127:0] prod;
   logic [41:0]  delta;
   logic [63:0]  mul_a, mul_b;

   logic              neg, speed_pos, want, head_ok, fast_slot;
   logic [15:0]       mag_raw, mag, cap16;
   logic [31:0]       diff, togo, pos_step;
   logic [22:0]       a_eff;
   logic [63:0]       e;
   logic [SLOT_W-1:0] slot_next;
   logic [31:0]       d_minus_one;
   logic [41:0]       dl, s;
   logic [32:0]       round_sum;
   logic [16:0]       round17;
   logic [16:0]       wr_cap;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      neg       = raw_ff[15];
      mag_raw   = neg ? (16'd0 - raw_ff) : raw_ff;
      cap16     = {1'b0, speed_limit_ff};
      mag       = (mag_raw > cap16) ? cap16 : mag_raw;
      speed_pos = (mag != 16'd0) && !neg;
      diff      = tp_ff - pos_ff;
      togo      = diff[31] ? (32'd0 - diff) : diff;
      want      = mode_ff ? (diff != 32'd0 && !diff[31]) : speed_pos;
      head_ok   = want ^ rev_ff;
      fast_slot = (slot_ff[2:0] != 3'd0) && (d_ff < srpg_pkg::FAST_Q);
      a_eff     = (mode_ff && d_ff < srpg_pkg::FAST_Q) ? {accel_ff, 3'b0}
                                                       : {3'b0, accel_ff};
      pos_step  = rev_ff ? (pos_ff - 32'd1) : (pos_ff + 32'd1);
      e         = up_ff ? (FQ + {32'b0, d_ff}) : (FQ - {32'b0, d_ff});
      slot_next = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
      d_minus_one = d_ff - srpg_pkg::ONE_Q;
      dl        = (delta > STEP_CLAMP) ? STEP_CLAMP : delta;
      s         = {10'b0, d_ff} + dl;
      round_sum = {1'b0, d_ff} + 33'h0_0000_8000;
      round17   = round_sum[32:16];
      wr_cap    = {1'b0, csr_wdata[14:0]};
   end

   always_comb begin
      case (op_ff)
         OP_DD:   begin mul_a = {32'b0, d_ff};  mul_b = {32'b0, d_ff}; end
         OP_TOGO: begin mul_a = {32'b0, togo};  mul_b = {42'b0, accel_ff, 2'b0}; end
         OP_ROOM: begin mul_a = t_ff;           mul_b = dd_ff; end
         OP_CMP:  begin
            mul_a = mode_ff ? {49'b0, speed_limit_ff} : {48'b0, mag};
            mul_b = {32'b0, d_ff};
         end
         OP_AD:   begin mul_a = {41'b0, a_eff}; mul_b = {32'b0, d_ff}; end
         OP_N:    begin mul_a = ad_ff;          mul_b = dd_ff; end
         default: begin mul_a = mode_ff ? FQ : e; mul_b = e; end
      endcase
   end

   srpg_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_issue_ff && !mul_stat.busy),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .stat  (mul_stat),
      .prod  (prod)
   );

   srpg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_issue_ff && !div_stat.busy),
      .num   (n_ff),
      .den   (p_ff),
      .stat  (div_stat),
      .quo   (delta)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      d_in         = d_ff;
      pos_in       = pos_ff;
      rev_in       = rev_ff;
      run_in       = run_ff;
      slot_in      = slot_ff;
      last_in      = last_ff;
      word_in      = word_ff;
      mul_issue_in = 1'b0;
      div_issue_in = 1'b0;
      dd_in        = dd_ff;
      t_in         = t_ff;
      ad_in        = ad_ff;
      n_in         = n_ff;
      p_in         = p_ff;
      room_big_in  = room_big_ff;
      up_in        = up_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (!run_ff) begin
               if (mode_ff ? (diff != 32'd0) : (mag != 16'd0)) begin
                  rev_in   = mode_ff ? (rev_ff ^ !head_ok) : neg;
                  d_in     = srpg_pkg::FULL_Q;
                  run_in   = 1'b1;
                  slot_in  = '0;
                  state_in = ST_PLAN;
               end else begin
                  word_in  = srpg_pkg::OFF_WORD;
                  state_in = ST_FIN;
               end
            end else begin
               // buffer boundary at full period: turn around if heading away
               if (slot_ff == '0 && d_ff >= srpg_pkg::FULL_Q && !head_ok) begin
                  rev_in = !rev_ff;
               end
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            if (mode_ff && fast_slot) begin
               word_in  = last_ff;
               pos_in   = pos_step;
               slot_in  = slot_next;
               state_in = ST_FIN;
            end else if (mode_ff && togo == 32'd0 && d_ff >= srpg_pkg::STOP_Q) begin
               word_in  = srpg_pkg::OFF_WORD;
               last_in  = srpg_pkg::OFF_WORD;
               slot_in  = slot_next;
               state_in = ST_FIN;
            end else begin
               op_in        = OP_DD;
               mul_issue_in = 1'b1;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_stat.done) begin
               mul_issue_in = 1'b1;
               case (op_ff)
                  OP_DD:   begin dd_in = prod[63:0]; op_in = OP_TOGO; end
                  OP_TOGO: begin t_in = prod[63:0];  op_in = OP_ROOM; end
                  OP_ROOM: begin room_big_in = BRAKE < prod; op_in = OP_CMP; end
                  OP_CMP:  begin
                     up_in = head_ok && (mode_ff ? (room_big_ff && prod > FQ_W)
                                                 : (prod < FQ_W));
                     op_in = OP_AD;
                  end
                  OP_AD:   begin ad_in = prod[63:0]; op_in = OP_N; end
                  OP_N:    begin n_in = prod; op_in = OP_P; end
                  default: begin
                     p_in         = prod;
                     mul_issue_in = 1'b0;
                     div_issue_in = 1'b1;
                     state_in     = ST_DIV;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (up_ff) begin
               d_in = (delta >= {10'b0, d_minus_one}) ? srpg_pkg::ONE_Q
                                                       : d_ff - delta[31:0];
            end else if (s[41:32] != 10'd0) begin
               d_in = mode_ff ? srpg_pkg::FULL_Q : srpg_pkg::SAT_Q;
            end else begin
               d_in = s[31:0];
            end
            state_in = ST_WORD;
         end
         ST_WORD: begin
            if (mode_ff) begin
               word_in = round17[16] ? 16'hFFFF : round17[15:0];
               pos_in  = pos_step;
            end else begin
               word_in = round17[16] ? srpg_pkg::OFF_WORD : round17[15:0];
            end
            last_in  = word_in;
            slot_in  = slot_next;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         op_ff          <= OP_DD;
         d_ff           <= srpg_pkg::FULL_Q;
         pos_ff         <= '0;
         rev_ff         <= 1'b0;
         run_ff         <= 1'b0;
         slot_ff        <= '0;
         last_ff        <= srpg_pkg::LAST_RST;
         mul_issue_ff   <= 1'b0;
         div_issue_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         speed_limit_ff <= SPEED_LIMIT_RST;
         accel_ff       <= srpg_pkg::ACCEL_RST;
         invert_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         d_ff         <= d_in;
         pos_ff       <= pos_in;
         rev_ff       <= rev_in;
         run_ff       <= run_in;
         slot_ff      <= slot_in;
         last_ff      <= last_in;
         mul_issue_ff <= mul_issue_in;
         div_issue_ff <= div_issue_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               srpg_pkg::CSR_SPEED_LIMIT: begin
                  speed_limit_ff <= (wr_cap > SPEED_CAP_W) ? SPEED_CAP_W[14:0]
                                                           : csr_wdata[14:0];
               end
               srpg_pkg::CSR_ACCEL:  accel_ff  <= csr_wdata;
               srpg_pkg::CSR_INVERT: invert_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff <= req_target_is_position;
         tp_ff   <= req_target_position;
         raw_ff  <= req_target_speed;
      end
      word_ff     <= word_in;
      dd_ff       <= dd_in;
      t_ff        <= t_in;
      ad_ff       <= ad_in;
      n_ff        <= n_in;
      p_ff        <= p_in;
      room_big_ff <= room_big_in;
      up_ff       <= up_in;
      if (rsp_load) begin
         rsp_word_ff <= word_ff;
         rsp_dir_ff  <= rev_ff ^ invert_ff;
         rsp_pos_ff  <= pos_ff;
         rsp_run_ff  <= run_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_period_word  = rsp_word_ff;
   assign rsp_dir_pin      = rsp_dir_ff;
   assign rsp_position_now = rsp_pos_ff;
   assign rsp_is_running   = rsp_run_ff;
endmodule
`default_nettype wire

// ----- hdl/srpg_checker.sv -----
// Port-level checks for the stepper ramp period generator, bound to the top.
// Depends on stepper_ramp_period_generator_core_macros.svh.
`default_nettype none
`include "stepper_ramp_period_generator_core_macros.svh"
module srpg_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_period_word,
   input wire logic [31:0] rsp_position_now,
   input wire logic        rsp_is_running
);
   // a request keeps the block busy for at least the next cycle
   `SRPG_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // a stopped motor always reports the off period
   `SRPG_ASSERT_NOW(a_idle_off, clock, reset, rsp_valid && !rsp_is_running, rsp_period_word == 16'd3199)
   `SRPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SRPG_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_position_now) && $stable(rsp_period_word))
endmodule

bind stepper_ramp_period_generator_core srpg_checker u_srpg_checker (.*);
`default_nettype wire

// ----- sim/stepper_ramp_period_generator_core_tb.sv -----
// Self-checking bench for stepper_ramp_period_generator_core: bursty request
// traffic, stalling response side, slot-by-slot prediction of every result.
// Depends on srpg_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none

module stepper_ramp_period_generator_core_tb;

   localparam longint unsigned TICK      = srpg_pkg::TICK_HZ_DEF;
   localparam longint unsigned FQ        = TICK << 16;
   localparam int unsigned     SPEED_CAP = 32'(TICK / 3200 - 80);
   localparam int unsigned     SLOTS     = srpg_pkg::SLOTS_DEF;
   localparam int unsigned     LIMIT     = 3000000;

   typedef struct packed {
      logic [15:0] period;
      logic        dir;
      logic [31:0] pos;
      logic        run;
   } slot_result_type;

   class ramp_scoreboard_type;
      bit [14:0] speed_limit;
      bit [19:0] accel;
      bit        invert;
      bit [63:0] div_q;
      bit [31:0] pos;
      bit        rev;
      bit        run;
      int unsigned slot;
      bit [15:0] last_word;
      slot_result_type pending[$];
      int errors;

      function new();
         speed_limit = (SPEED_CAP > 32767) ? 15'd32767 : SPEED_CAP[14:0];
         accel = srpg_pkg::ACCEL_RST;
         invert = 0;
         div_q = 64'(srpg_pkg::FULL_Q);
         pos = 0;
         rev = 0;
         run = 0;
         slot = 0;
         last_word = srpg_pkg::LAST_RST;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [19:0] data);
         case (idx)
            srpg_pkg::CSR_SPEED_LIMIT:
               speed_limit = (data[14:0] > SPEED_CAP) ? SPEED_CAP[14:0] : data[14:0];
            srpg_pkg::CSR_ACCEL:  accel = data;
            srpg_pkg::CSR_INVERT: invert = data[0];
            default: ;
         endcase
      endfunction

      function bit heading_ok(bit mode, bit [31:0] tp, bit spd_pos);
         bit [31:0] diff;
         bit want;
         diff = tp - pos;
         want = mode ? (diff != 0 && !diff[31]) : spd_pos;
         return want ^ rev;
      endfunction

      // a*D^3 / (first*second) in Q16.16, saturating
      function bit [63:0] ramp_delta(bit [63:0] a, bit [63:0] first, bit [63:0] second);
         bit [63:0] ad, dd;
         bit [127:0] q;
         ad = a * div_q;
         dd = div_q * div_q;
         q = ({64'd0, ad} * {64'd0, dd}) / {64'd0, first};
         q = q / {64'd0, second};
         return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
      endfunction

      function void apply_delta(bit up, bit [63:0] delta, bit [63:0] cap_at, bit [63:0] cap_to);
         bit [63:0] s;
         if (up) begin
            if (delta >= div_q - 64'(srpg_pkg::ONE_Q)) div_q = 64'(srpg_pkg::ONE_Q);
            else div_q = div_q - delta;
         end else begin
            s = div_q + ((delta > (64'd1 << 40)) ? (64'd1 << 40) : delta);
            div_q = (s >= cap_at) ? cap_to : s;
         end
      endfunction

      function void note_request(bit mode, bit [31:0] tp, bit [15:0] raw);
         bit neg, spd_pos, start, up;
         bit [16:0] mag;
         bit [63:0] word, e, a;
         bit [31:0] diff, togo;
         bit [127:0] brake, room;
         slot_result_type r;
         neg = raw[15];
         mag = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
         if (mag > speed_limit) mag = {2'b0, speed_limit};
         spd_pos = (mag != 0) && !neg;
         if (!run) begin
            start = 0;
            if (!mode) begin
               if (mag != 0) begin
                  rev = neg;
                  start = 1;
               end
            end else if (tp != pos) begin
               if (!heading_ok(mode, tp, spd_pos)) rev = !rev;
               start = 1;
            end
            if (!start) begin
               r.period = srpg_pkg::OFF_WORD;
               r.dir = rev ^ invert;
               r.pos = pos;
               r.run = 0;
               pending.push_back(r);
               return;
            end
            div_q = 64'(srpg_pkg::FULL_Q);
            run = 1;
            slot = 0;
         end else if (slot == 0 && div_q >= srpg_pkg::FULL_Q &&
                      !heading_ok(mode, tp, spd_pos)) begin
            rev = !rev;
         end

         if (!mode) begin
            up = heading_ok(mode, tp, spd_pos) && ({47'd0, mag} * div_q < FQ);
            e = up ? FQ + div_q : FQ - div_q;
            apply_delta(up, ramp_delta({44'd0, accel}, e, e), 64'd1 << 32,
                        64'(srpg_pkg::SAT_Q));
            word = (div_q + 64'h8000) >> 16;
            if (word > 65535) word = 64'(srpg_pkg::OFF_WORD);
         end else begin
            diff = tp - pos;
            togo = diff[31] ? (32'd0 - diff) : diff;
            if ((slot % 8) != 0 && div_q < srpg_pkg::FAST_Q) begin
               // fast slots repeat the previous word
               word = {48'd0, last_word};
               pos = pos + (rev ? 32'hFFFF_FFFF : 32'd1);
            end else if (togo == 0 && div_q >= srpg_pkg::STOP_Q) begin
               word = 64'(srpg_pkg::OFF_WORD);
            end else begin
               up = 0;
               a = {44'd0, accel};
               if (heading_ok(mode, tp, spd_pos)) begin
                  brake = {64'd0, 3 * FQ} * {64'd0, FQ};
                  room = {64'd0, 64'(4 * {32'd0, togo} * a)} * {64'd0, 64'(div_q * div_q)};
                  up = (brake < room) && ({49'd0, speed_limit} * div_q > FQ);
               end
               if (div_q < srpg_pkg::FAST_Q) a = a * 8;
               e = up ? FQ + div_q : FQ - div_q;
               apply_delta(up, ramp_delta(a, FQ, e), 64'd1 << 32, 64'(srpg_pkg::FULL_Q));
               pos = pos + (rev ? 32'hFFFF_FFFF : 32'd1);
               word = (div_q + 64'h8000) >> 16;
               if (word > 65535) word = 64'd65535;
            end
         end
         last_word = word[15:0];
         slot = (slot + 1) % SLOTS;
         r.period = word[15:0];
         r.dir = rev ^ invert;
         r.pos = pos;
         r.run = 1;
         pending.push_back(r);
      endfunction

      function void check_result(slot_result_type got);
         slot_result_type want;
         if (pending.size() == 0) begin
            $error("unexpected response: period %0d pos %0d", got.period, got.pos);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.period !== want.period) begin
            $error("period_word: expected %0d, got %0d", want.period, got.period);
            errors++;
         end
         if (got.dir !== want.dir) begin
            $error("dir_pin: expected %0d, got %0d", want.dir, got.dir);
            errors++;
         end
         if (got.pos !== want.pos) begin
            $error("position_now: expected %0d, got %0d", $signed(want.pos), $signed(got.pos));
            errors++;
         end
         if (got.run !== want.run) begin
            $error("is_running: expected %0d, got %0d", want.run, got.run);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_target_is_position;
   logic [31:0] req_target_position;
   logic [15:0] req_target_speed;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_period_word;
   logic        rsp_dir_pin;
   logic [31:0] rsp_position_now;
   logic        rsp_is_running;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [19:0] csr_wdata;

   ramp_scoreboard_type sb;
   int unsigned cycles;
   int          rsp_style;
   bit          hold_request;
   int          hold_left;
   int          stall_phase;
   bit          gaps_on;
   int          burst_left;
   int          sent;

   stepper_ramp_period_generator_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_target_is_position(req_target_is_position),
      .req_target_position(req_target_position),
      .req_target_speed(req_target_speed),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_period_word(rsp_period_word),
      .rsp_dir_pin(rsp_dir_pin),
      .rsp_position_now(rsp_position_now),
      .rsp_is_running(rsp_is_running),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // response side: own stall pattern plus an occasional long hold-off
   always @(negedge clock) begin
      stall_phase = stall_phase + 1;
      if (hold_request && hold_left == 0) begin
         hold_left = 600;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (rsp_style)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ((stall_phase % 11) < 6);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_period_word, rsp_dir_pin, rsp_position_now, rsp_is_running});
   end

   task automatic csr_write(logic [1:0] idx, logic [19:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // valid stays up across back-to-back requests; a gap lowers it
   task automatic send_req(bit mode, bit [31:0] tp, bit [15:0] spd);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_target_is_position <= mode;
      req_target_position <= tp;
      req_target_speed <= spd;
      do @(posedge clock); while (!req_ready);
      sb.note_request(mode, tp, spd);
      sent++;
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 25);
            gap = $urandom_range(1, 12);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // stop offering before waiting, so the last request is not taken twice
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   function automatic bit [15:0] rand_speed();
      return 16'($signed($urandom_range(0, 38902)) - 19451);
   endfunction

   task automatic run_random(int count);
      int goal, off, len, i;
      bit [31:0] tgt;
      bit [15:0] spd;
      goal = sent + count;
      while (sent < goal) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               off = $urandom_range(1, 300);
               if ($urandom_range(0, 1)) off = -off;
               tgt = sb.pos + 32'(off);
               len = (off < 0 ? -off : off) + $urandom_range(0, 40);
               for (i = 0; i < len && sent < goal; i++) send_req(1'b1, tgt, rand_speed());
            end
            5, 6, 7: begin
               spd = rand_speed();
               len = $urandom_range(10, 60);
               for (i = 0; i < len && sent < goal; i++) send_req(1'b0, 32'($urandom), spd);
            end
            default: begin
               len = $urandom_range(1, 5);
               for (i = 0; i < len; i++)
                  send_req(1'($urandom_range(0, 1)), 32'($urandom), rand_speed());
            end
         endcase
      end
   endtask

   initial begin
      sb = new();
      cycles = 0;
      rsp_style = 0;
      hold_request = 0;
      hold_left = 0;
      stall_phase = 0;
      gaps_on = 0;
      burst_left = 0;
      sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_target_is_position = 1'b0;
      req_target_position = '0;
      req_target_speed = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = srpg_pkg::CSR_SPEED_LIMIT;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle slots first, then start and the extremes
      send_req(1'b0, 32'h0, 16'd0);
      send_req(1'b1, 32'h0, 16'd0);
      send_req(1'b0, 32'h0, 16'h8000 + 16'd0);
      send_req(1'b0, 32'hFFFF_FFFF, 16'(-19451));
      send_req(1'b0, 32'h0, 16'(-19451));
      send_req(1'b0, 32'h0, 16'd19451);
      send_req(1'b0, 32'h0, 16'd19451);
      send_req(1'b0, 32'h0, 16'hFFFF);
      send_req(1'b0, 32'h0, 16'd0);
      send_req(1'b1, 32'h7FFF_FFFF, 16'd0);
      send_req(1'b1, 32'h8000_0000, 16'd0);
      send_req(1'b1, 32'h8000_0000, 16'd19451);
      send_req(1'b1, sb.pos, 16'd0);
      send_req(1'b1, sb.pos, 16'd0);
      repeat (8) send_req(1'b1, sb.pos + 32'd3, 16'd0);
      run_random(180);
      drain();

      csr_write(srpg_pkg::CSR_SPEED_LIMIT, 20'd19451);
      csr_write(srpg_pkg::CSR_ACCEL, 20'hFFFFF);
      csr_write(srpg_pkg::CSR_INVERT, 20'd1);
      gaps_on = 1;
      rsp_style = 1;
      run_random(200);
      drain();

      csr_write(srpg_pkg::CSR_SPEED_LIMIT, 20'd0);
      csr_write(srpg_pkg::CSR_ACCEL, 20'd1);
      rsp_style = 2;
      run_random(150);
      drain();

      csr_write(srpg_pkg::CSR_SPEED_LIMIT, 20'hFFFFF);
      csr_write(srpg_pkg::CSR_ACCEL, 20'd50000);
      csr_write(srpg_pkg::CSR_INVERT, 20'd0);
      gaps_on = 0;
      rsp_style = 1;
      hold_request = 1;
      run_random(200);
      drain();

      csr_write(srpg_pkg::CSR_SPEED_LIMIT, 20'($urandom));
      csr_write(srpg_pkg::CSR_ACCEL, 20'($urandom_range(1, 20'hFFFFF)));
      csr_write(srpg_pkg::CSR_INVERT, 20'($urandom));
      gaps_on = 1;
      rsp_style = 0;
      run_random(200);
      drain();

      csr_write(srpg_pkg::CSR_SPEED_LIMIT, 20'd500);
      csr_write(srpg_pkg::CSR_ACCEL, 20'd200000);
      csr_write(srpg_pkg::CSR_INVERT, 20'd1);
      rsp_style = 2;
      hold_request = 1;
      run_random(200);
      drain();

      csr_write(srpg_pkg::CSR_SPEED_LIMIT, 20'($urandom_range(1000, 19451)));
      csr_write(srpg_pkg::CSR_ACCEL, 20'($urandom_range(1, 300000)));
      rsp_style = 1;
      run_random(200);

      drain();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
